// ===== sv/rbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types and widths for the 2D ray versus box intersection pipeline.
// ----------------------------------------------------------------------------
package rbi_pkg;

    // Q16.16 word width
    localparam int unsigned WordW  = 32;
    // fraction bits
    localparam int unsigned FracW  = 16;
    // face offset magnitude (exact 33-bit difference)
    localparam int unsigned DiffW  = WordW + 1;
    // scaled numerator magnitude and full quotient width
    localparam int unsigned NumW   = DiffW + FracW;
    // number of slab divisions per item
    localparam int unsigned Lanes  = 4;
    // lane codes
    localparam int unsigned LaneXl = 0;
    localparam int unsigned LaneXr = 1;
    localparam int unsigned LaneYt = 2;
    localparam int unsigned LaneYb = 3;

    typedef logic signed [WordW-1:0] word_t;

    // fields that ride alongside the dividers
    typedef struct packed {
        word_t ox;
        word_t oy;
        word_t dx;
        word_t dy;
        word_t len;
        logic  ax_sel;
        logic  ax_hit;
        word_t ax_hx;
        word_t ax_hy;
    } meta_t;

    // one restoring divider lane
    typedef struct packed {
        logic [NumW-1:0]  num;
        logic [WordW-1:0] den;
        logic [WordW-1:0] rem;
        logic [NumW-1:0]  quo;
        logic             neg;
    } lane_t;

endpackage

// ===== sv/rbi_in_if.sv =====
// ----------------------------------------------------------------------------
// rbi_in_if
// Ray and box transfer channel.
// ----------------------------------------------------------------------------
interface rbi_in_if;
    logic           valid;
    logic           ready;
    rbi_pkg::word_t origin_x;
    rbi_pkg::word_t origin_y;
    rbi_pkg::word_t dir_x;
    rbi_pkg::word_t dir_y;
    rbi_pkg::word_t ray_len;
    rbi_pkg::word_t box_left;
    rbi_pkg::word_t box_top;
    rbi_pkg::word_t box_right;
    rbi_pkg::word_t box_bottom;

    modport source (output valid, origin_x, origin_y, dir_x, dir_y, ray_len,
                    box_left, box_top, box_right, box_bottom, input ready);
    modport sink   (input valid, origin_x, origin_y, dir_x, dir_y, ray_len,
                    box_left, box_top, box_right, box_bottom, output ready);
endinterface

// ===== sv/rbi_out_if.sv =====
// ----------------------------------------------------------------------------
// rbi_out_if
// Hit result transfer channel.
// ----------------------------------------------------------------------------
interface rbi_out_if;
    logic           valid;
    logic           ready;
    logic           is_hit;
    rbi_pkg::word_t hit_x;
    rbi_pkg::word_t hit_y;

    modport source (output valid, is_hit, hit_x, hit_y, input ready);
    modport sink   (input valid, is_hit, hit_x, hit_y, output ready);
endinterface

// ===== sv/ray_box_intersect_2d.sv =====
// ----------------------------------------------------------------------------
// ray_box_intersect_2d
// Pipelined 2D ray versus axis-aligned box test in signed Q16.16.
// ----------------------------------------------------------------------------
// One ray/box pair is taken per cycle and one result leaves per cycle while
// no result is stuck. Behind the entry stage sit four restoring dividers
// (one per slab face) that resolve one quotient bit per stage over 49
// stages, followed by saturation, the slab compare, the hit-point multiply
// and the final add. The whole pipeline holds while a result waits.
// ----------------------------------------------------------------------------
module ray_box_intersect_2d (
    input  logic clk,
    input  logic rst_n,
    rbi_in_if.sink    query,
    rbi_out_if.source answer
);
    localparam int unsigned NW = rbi_pkg::NumW;
    localparam int unsigned WW = rbi_pkg::WordW;
    localparam int unsigned DS = NW; // divider stages

    logic en;

    // divider pipeline, index 0 is the entry stage
    logic          dvld_reg  [0:DS];
    rbi_pkg::meta_t dmeta_reg [0:DS];
    rbi_pkg::lane_t dlane_reg [0:DS][0:rbi_pkg::Lanes-1];

    // later stages
    logic           c_vld_reg, d_vld_reg, e_vld_reg, o_vld_reg;
    rbi_pkg::meta_t c_meta_reg, d_meta_reg, e_meta_reg;
    rbi_pkg::word_t c_q_reg [0:rbi_pkg::Lanes-1];
    rbi_pkg::word_t d_t_reg;
    logic           d_hit_reg, e_hit_reg;
    logic signed [2*WW-1:0] e_px_reg, e_py_reg;
    logic           o_hit_reg;
    rbi_pkg::word_t o_hx_reg, o_hy_reg;

    // pipeline advances unless a result is stuck
    assign en          = !o_vld_reg || answer.ready;
    assign query.ready = en;

    // ---------------- entry stage: offsets and axis-aligned test -----------
    rbi_pkg::meta_t a_meta_next;
    rbi_pkg::lane_t a_lane_next [0:rbi_pkg::Lanes-1];
    logic signed [WW:0] a_diff [0:rbi_pkg::Lanes-1];
    logic signed [WW:0] ex_ox, ex_oy, ex_len, ex_bl, ex_bt, ex_br, ex_bb;

    always_comb
    begin
        ex_ox  = {query.origin_x[WW-1], query.origin_x};
        ex_oy  = {query.origin_y[WW-1], query.origin_y};
        ex_len = {query.ray_len[WW-1], query.ray_len};
        ex_bl  = {query.box_left[WW-1], query.box_left};
        ex_bt  = {query.box_top[WW-1], query.box_top};
        ex_br  = {query.box_right[WW-1], query.box_right};
        ex_bb  = {query.box_bottom[WW-1], query.box_bottom};
        a_diff[rbi_pkg::LaneXl] = ex_bl - ex_ox;
        a_diff[rbi_pkg::LaneXr] = ex_br - ex_ox;
        a_diff[rbi_pkg::LaneYt] = ex_bt - ex_oy;
        a_diff[rbi_pkg::LaneYb] = ex_bb - ex_oy;

        a_meta_next.ox  = query.origin_x;
        a_meta_next.oy  = query.origin_y;
        a_meta_next.dx  = query.dir_x;
        a_meta_next.dy  = query.dir_y;
        a_meta_next.len = query.ray_len;
        a_meta_next.ax_hit = 1'b0;
        a_meta_next.ax_hx  = query.origin_x;
        a_meta_next.ax_hy  = query.origin_y;
        a_meta_next.ax_sel = (query.dir_x == '0) || (query.dir_y == '0);

        if (query.dir_x == '0)
        begin
            // vertical ray
            if (!(query.origin_x < query.box_left || query.origin_x > query.box_right))
            begin
                if (query.dir_y[WW-1])
                begin
                    a_meta_next.ax_hit = (query.origin_y > query.box_top) &&
                                         ((ex_oy - ex_bb) < ex_len);
                    a_meta_next.ax_hy  = query.box_bottom;
                end
                else
                begin
                    a_meta_next.ax_hit = (query.origin_y < query.box_bottom) &&
                                         ((ex_bt - ex_oy) < ex_len);
                    a_meta_next.ax_hy  = query.box_top;
                end
            end
        end
        else if (query.dir_y == '0)
        begin
            // horizontal ray
            if (!(query.origin_y < query.box_top || query.origin_y > query.box_bottom))
            begin
                if (query.dir_x[WW-1])
                begin
                    a_meta_next.ax_hit = (query.origin_x > query.box_left) &&
                                         ((ex_ox - ex_br) < ex_len);
                    a_meta_next.ax_hx  = query.box_right;
                end
                else
                begin
                    a_meta_next.ax_hit = (query.origin_x < query.box_right) &&
                                         ((ex_bl - ex_ox) < ex_len);
                    a_meta_next.ax_hx  = query.box_left;
                end
            end
        end

        // divider lane setup: magnitudes, scaled numerator, sign of result
        for (int i = 0; i < rbi_pkg::Lanes; i++)
        begin
            logic [WW:0]    mag;
            rbi_pkg::word_t dv;
            mag = a_diff[i][WW] ? (WW+1)'(-a_diff[i]) : a_diff[i];
            dv  = (i <= rbi_pkg::LaneXr) ? query.dir_x : query.dir_y;
            a_lane_next[i].num = {mag, {rbi_pkg::FracW{1'b0}}};
            a_lane_next[i].den = dv[WW-1] ? WW'(-dv) : dv;
            a_lane_next[i].rem = '0;
            a_lane_next[i].quo = '0;
            a_lane_next[i].neg = a_diff[i][WW] ^ dv[WW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvld_reg[0] <= 1'b0;
        else if (en)
            dvld_reg[0] <= query.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmeta_reg[0] <= a_meta_next;
            for (int i = 0; i < rbi_pkg::Lanes; i++)
                dlane_reg[0][i] <= a_lane_next[i];
        end
    end

    // ---------------- restoring divider, one quotient bit per stage --------
    for (genvar s = 1; s <= DS; s++)
    begin : g_div
        localparam int unsigned K = DS - s;
        rbi_pkg::lane_t lane_next [0:rbi_pkg::Lanes-1];

        always_comb
        begin
            for (int i = 0; i < rbi_pkg::Lanes; i++)
            begin
                logic [WW:0] trial;
                lane_next[i] = dlane_reg[s-1][i];
                trial = {dlane_reg[s-1][i].rem, dlane_reg[s-1][i].num[K]};
                if (trial >= {1'b0, dlane_reg[s-1][i].den})
                begin
                    trial = trial - {1'b0, dlane_reg[s-1][i].den};
                    lane_next[i].quo[K] = 1'b1;
                end
                lane_next[i].rem = trial[WW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvld_reg[s] <= 1'b0;
            else if (en)
                dvld_reg[s] <= dvld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dmeta_reg[s] <= dmeta_reg[s-1];
                for (int i = 0; i < rbi_pkg::Lanes; i++)
                    dlane_reg[s][i] <= lane_next[i];
            end
        end
    end

    // ---------------- sign, saturate, near/far swap ------------------------
    rbi_pkg::word_t c_sat [0:rbi_pkg::Lanes-1];
    rbi_pkg::word_t c_q_next [0:rbi_pkg::Lanes-1];

    always_comb
    begin
        for (int i = 0; i < rbi_pkg::Lanes; i++)
        begin
            logic [NW-1:0] q;
            q = dlane_reg[DS][i].quo;
            if (dlane_reg[DS][i].neg)
            begin
                if ((|q[NW-1:WW]) || (q[WW-1] && (|q[WW-2:0])))
                    c_sat[i] = {1'b1, {(WW-1){1'b0}}};
                else
                    c_sat[i] = WW'(-q[WW-1:0]);
            end
            else
            begin
                if (|q[NW-1:WW-1])
                    c_sat[i] = {1'b0, {(WW-1){1'b1}}};
                else
                    c_sat[i] = q[WW-1:0];
            end
        end
        // order: x near, x far, y near, y far
        c_q_next[0] = dmeta_reg[DS].dx[WW-1] ? c_sat[rbi_pkg::LaneXr] : c_sat[rbi_pkg::LaneXl];
        c_q_next[1] = dmeta_reg[DS].dx[WW-1] ? c_sat[rbi_pkg::LaneXl] : c_sat[rbi_pkg::LaneXr];
        c_q_next[2] = dmeta_reg[DS].dy[WW-1] ? c_sat[rbi_pkg::LaneYb] : c_sat[rbi_pkg::LaneYt];
        c_q_next[3] = dmeta_reg[DS].dy[WW-1] ? c_sat[rbi_pkg::LaneYt] : c_sat[rbi_pkg::LaneYb];
    end

    // ---------------- slab overlap and entry distance ----------------------
    logic           d_hit_next;
    rbi_pkg::word_t d_t_next;

    always_comb
    begin
        d_t_next   = (c_q_reg[0] > c_q_reg[2]) ? c_q_reg[0] : c_q_reg[2];
        d_hit_next = !((c_q_reg[0] > c_q_reg[3]) || (c_q_reg[2] > c_q_reg[1])) &&
                     !d_t_next[WW-1] && (d_t_next <= c_meta_reg.len);
    end

    // ---------------- hit point: origin + floor(d * t / 2^16) --------------
    logic signed [2*WW-rbi_pkg::FracW-1:0] f_sx, f_sy;
    logic signed [2*WW-rbi_pkg::FracW:0]   f_ax, f_ay;
    rbi_pkg::word_t f_hx, f_hy;
    logic           o_hit_next;
    rbi_pkg::word_t o_hx_next, o_hy_next;

    always_comb
    begin
        f_sx = e_px_reg[2*WW-1:rbi_pkg::FracW];
        f_sy = e_py_reg[2*WW-1:rbi_pkg::FracW];
        f_ax = {{(WW-rbi_pkg::FracW+1){e_meta_reg.ox[WW-1]}}, e_meta_reg.ox} +
               {f_sx[2*WW-rbi_pkg::FracW-1], f_sx};
        f_ay = {{(WW-rbi_pkg::FracW+1){e_meta_reg.oy[WW-1]}}, e_meta_reg.oy} +
               {f_sy[2*WW-rbi_pkg::FracW-1], f_sy};
        if (f_ax > $signed({1'b0, {(WW-1){1'b1}}}))
            f_hx = {1'b0, {(WW-1){1'b1}}};
        else if (f_ax < -$signed({1'b0, 1'b1, {(WW-1){1'b0}}}))
            f_hx = {1'b1, {(WW-1){1'b0}}};
        else
            f_hx = f_ax[WW-1:0];
        if (f_ay > $signed({1'b0, {(WW-1){1'b1}}}))
            f_hy = {1'b0, {(WW-1){1'b1}}};
        else if (f_ay < -$signed({1'b0, 1'b1, {(WW-1){1'b0}}}))
            f_hy = {1'b1, {(WW-1){1'b0}}};
        else
            f_hy = f_ay[WW-1:0];

        // pick axis-aligned or slab answer, zero on miss
        if (e_meta_reg.ax_sel)
        begin
            o_hit_next = e_meta_reg.ax_hit;
            o_hx_next  = e_meta_reg.ax_hx;
            o_hy_next  = e_meta_reg.ax_hy;
        end
        else
        begin
            o_hit_next = e_hit_reg;
            o_hx_next  = f_hx;
            o_hy_next  = f_hy;
        end
        if (!o_hit_next)
        begin
            o_hx_next = '0;
            o_hy_next = '0;
        end
    end

    // ---------------- back-end registers -----------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= dvld_reg[DS];
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            o_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_meta_reg <= dmeta_reg[DS];
            for (int i = 0; i < rbi_pkg::Lanes; i++)
                c_q_reg[i] <= c_q_next[i];
            d_meta_reg <= c_meta_reg;
            d_t_reg    <= d_t_next;
            d_hit_reg  <= d_hit_next;
            e_meta_reg <= d_meta_reg;
            e_hit_reg  <= d_hit_reg;
            e_px_reg   <= d_meta_reg.dx * d_t_reg;
            e_py_reg   <= d_meta_reg.dy * d_t_reg;
            o_hit_reg  <= o_hit_next;
            o_hx_reg   <= o_hx_next;
            o_hy_reg   <= o_hy_next;
        end
    end

    assign answer.valid  = o_vld_reg;
    assign answer.is_hit = o_hit_reg;
    assign answer.hit_x  = o_hx_reg;
    assign answer.hit_y  = o_hy_reg;

endmodule

// ===== sv/rbi_checker.sv =====
// ----------------------------------------------------------------------------
// rbi_checker
// Port-level checks for the ray versus box pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rbi_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input logic           is_hit,
    input rbi_pkg::word_t hit_x,
    input rbi_pkg::word_t hit_y
);
    // a miss reports the origin of coordinates
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_hit) |-> (hit_x == '0 && hit_y == '0))
        else $error("miss result with nonzero point");

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(is_hit) &&
                                       $stable(hit_x) && $stable(hit_y)))
        else $error("stalled result changed");

    // input side is open whenever the output register is free or drains
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled while output free");

    // input side stalls only behind a stuck result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // handshake lines stay known out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid, out_ready}))
        else $error("handshake signal unknown");

endmodule

bind ray_box_intersect_2d rbi_checker u_rbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .out_valid (answer.valid),
    .out_ready (answer.ready),
    .is_hit    (answer.is_hit),
    .hit_x     (answer.hit_x),
    .hit_y     (answer.hit_y)
);

// ===== dv/rbi_hit_board.sv =====
// ----------------------------------------------------------------------------
// rbi_hit_board
// Predicts the hit answer for every accepted ray/box pair and checks the
// answers the block returns, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class rbi_hit_board;

    typedef struct {
        logic        is_hit;
        logic [31:0] hit_x;
        logic [31:0] hit_y;
    } hit_t;

    hit_t pending[$];
    int   errors;
    int   checked;
    int   hits;
    int   axis_rays;
    int   slab_rays;

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // face distance in Q16.16, truncated toward zero and saturated
    static function longint slab_dist(longint num, longint den);
        return clamp32((num * 65536) / den);
    endfunction

    // origin plus floor(d * t / 2^16), saturated; d * t fits in 63 bits
    static function longint step_along(longint o, longint d, longint t);
        longint p;
        longint s;
        p = d * t;
        if (p >= 0) s = p / 65536;
        else s = -((-p + 65535) / 65536);
        return clamp32(o + s);
    endfunction

    function void note_query(logic signed [31:0] ox32, logic signed [31:0] oy32,
                             logic signed [31:0] dx32, logic signed [31:0] dy32,
                             logic signed [31:0] len32,
                             logic signed [31:0] bl32, logic signed [31:0] bt32,
                             logic signed [31:0] br32, logic signed [31:0] bb32);
        longint ox, oy, dx, dy, len, bl, bt, br, bb;
        longint xn, xf, yn, yf, t, hx, hy;
        hit_t   e;
        ox = ox32; oy = oy32; dx = dx32; dy = dy32; len = len32;
        bl = bl32; bt = bt32; br = br32; bb = bb32;
        e.is_hit = 1'b0;
        hx = 0;
        hy = 0;
        if (dx == 0) begin
            // vertical path, also taken by a zero direction
            axis_rays++;
            if (!(ox < bl || ox > br)) begin
                if (dy < 0) begin
                    if (oy > bt && oy - bb < len) begin
                        e.is_hit = 1'b1; hx = ox; hy = bb;
                    end
                end
                else if (oy < bb && bt - oy < len) begin
                    e.is_hit = 1'b1; hx = ox; hy = bt;
                end
            end
        end
        else if (dy == 0) begin
            axis_rays++;
            if (!(oy < bt || oy > bb)) begin
                if (dx < 0) begin
                    if (ox > bl && ox - br < len) begin
                        e.is_hit = 1'b1; hx = br; hy = oy;
                    end
                end
                else if (ox < br && bl - ox < len) begin
                    e.is_hit = 1'b1; hx = bl; hy = oy;
                end
            end
        end
        else begin
            slab_rays++;
            if (dx < 0) begin
                xn = slab_dist(br - ox, dx); xf = slab_dist(bl - ox, dx);
            end
            else begin
                xn = slab_dist(bl - ox, dx); xf = slab_dist(br - ox, dx);
            end
            if (dy < 0) begin
                yn = slab_dist(bb - oy, dy); yf = slab_dist(bt - oy, dy);
            end
            else begin
                yn = slab_dist(bt - oy, dy); yf = slab_dist(bb - oy, dy);
            end
            if (!(xn > yf || yn > xf)) begin
                t = (xn > yn) ? xn : yn;
                if (t >= 0 && t <= len) begin
                    e.is_hit = 1'b1;
                    hx = step_along(ox, dx, t);
                    hy = step_along(oy, dy, t);
                end
            end
        end
        e.hit_x = e.is_hit ? hx[31:0] : 32'd0;
        e.hit_y = e.is_hit ? hy[31:0] : 32'd0;
        pending.insert(pending.size(), e);
    endfunction

    function void check_answer(logic is_hit, logic [31:0] hit_x, logic [31:0] hit_y);
        hit_t e;
        checked++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected answer hit=%b x=%h y=%h", $time, is_hit, hit_x, hit_y);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (is_hit) hits++;
        if (is_hit !== e.is_hit) begin
            $display("%0t: is_hit expected %b actual %b", $time, e.is_hit, is_hit);
            errors++;
        end
        if (hit_x !== e.hit_x) begin
            $display("%0t: hit_x expected %h actual %h", $time, e.hit_x, hit_x);
            errors++;
        end
        if (hit_y !== e.hit_y) begin
            $display("%0t: hit_y expected %h actual %h", $time, e.hit_y, hit_y);
            errors++;
        end
    endfunction

endclass

// ===== dv/ray_box_intersect_2d_tb.sv =====
// ----------------------------------------------------------------------------
// ray_box_intersect_2d_tb
// Streams directed and random ray/box pairs through the pipeline with random
// gaps and back-pressure, and checks every answer against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_box_intersect_2d_tb;

    localparam int NumRandom = 900;
    localparam int PipeDepth = 54;
    localparam longint CycleLimit = 400000;

    logic clk;
    logic rst_n;
    logic stall_on;
    longint cycles = 0;
    int   sent = 0;

    rbi_in_if  query ();
    rbi_out_if answer ();

    rbi_hit_board board;

    ray_box_intersect_2d dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .answer (answer.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // note accepted queries, check accepted answers
    always @(posedge clk)
    begin
        if (rst_n && query.valid && query.ready)
        begin
            board.note_query(query.origin_x, query.origin_y, query.dir_x, query.dir_y,
                             query.ray_len, query.box_left, query.box_top,
                             query.box_right, query.box_bottom);
            sent <= sent + 1;
        end
        if (rst_n && answer.valid && answer.ready)
            board.check_answer(answer.is_hit, answer.hit_x, answer.hit_y);
    end

    // one ray/box transfer, after a random gap
    task automatic send_ray(input logic [31:0] ox, oy, dx, dy, len, bl, bt, br, bb);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            query.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        query.valid      <= 1'b1;
        query.origin_x   <= ox;
        query.origin_y   <= oy;
        query.dir_x      <= dx;
        query.dir_y      <= dy;
        query.ray_len    <= len;
        query.box_left   <= bl;
        query.box_top    <= bt;
        query.box_right  <= br;
        query.box_bottom <= bb;
        @(posedge clk);
        while (!query.ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'd0;
            3: return $urandom;
            default: return $signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64;
        endcase
    endfunction

    // ray aimed at a small box near the origin, hits often
    task automatic send_aimed();
        logic signed [31:0] ox, oy, dx, dy, len, bl, bt, br, bb;
        bl = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        bt = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        br = bl + $urandom_range(0, 10 << 16);
        bb = bt + $urandom_range(0, 10 << 16);
        ox = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
        oy = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
        dx = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
        dy = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
        case ($urandom_range(0, 5))
            0: dx = 0;
            1: dy = 0;
            2: begin dx = 0; dy = 0; end
            default: ;
        endcase
        len = $urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 200 << 16);
        send_ray(ox, oy, dx, dy, len, bl, bt, br, bb);
    endtask

    // answer side: random ready gaps, plus one long hold-off
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        answer.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_on && !held)
            begin
                answer.ready <= 1'b0;
                repeat (300) @(negedge clk);
                held = 1'b1;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                answer.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            answer.ready <= 1'b1;
        end
    end

    initial
    begin
        int wait_cnt;
        board = new();
        stall_on = 1'b0;
        rst_n = 1'b0;
        query.valid = 1'b0;
        query.origin_x = '0; query.origin_y = '0;
        query.dir_x = '0; query.dir_y = '0; query.ray_len = '0;
        query.box_left = '0; query.box_top = '0;
        query.box_right = '0; query.box_bottom = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: axis paths, inside-box quirk, zero direction, slab, extremes
        send_ray(5 << 16, 0, 0, -(1 << 16), 100 << 16, 0, 20 << 16, 10 << 16, 40 << 16);
        send_ray(5 << 16, 50 << 16, 0, -(1 << 16), 100 << 16, 0, 20 << 16, 10 << 16, 40 << 16);
        send_ray(5 << 16, 0, 0, 1 << 16, 100 << 16, 0, 20 << 16, 10 << 16, 40 << 16);
        send_ray(5 << 16, 0, 0, 1 << 16, 20 << 16, 0, 20 << 16, 10 << 16, 40 << 16);
        send_ray(5 << 16, 0, 0, 0, 100 << 16, 0, 20 << 16, 10 << 16, 40 << 16);
        send_ray(0, 30 << 16, 1 << 16, 0, 100 << 16, 2 << 16, 20 << 16, 10 << 16, 40 << 16);
        send_ray(50 << 16, 30 << 16, -(1 << 16), 0, 100 << 16, 2 << 16, 20 << 16,
                 10 << 16, 40 << 16);
        send_ray(5 << 16, 30 << 16, 1 << 16, 0, 100 << 16, 2 << 16, 20 << 16,
                 10 << 16, 40 << 16);
        send_ray(5 << 16, 30 << 16, 0, 1 << 16, 100 << 16, 2 << 16, 20 << 16,
                 10 << 16, 40 << 16);
        send_ray(0, 0, 1 << 16, 1 << 16, 100 << 16, 10 << 16, 10 << 16, 20 << 16, 20 << 16);
        send_ray(30 << 16, 30 << 16, -(1 << 16), -(3 << 15), 100 << 16, 10 << 16,
                 10 << 16, 20 << 16, 20 << 16);
        send_ray(0, 0, 1 << 16, 1 << 16, 100 << 16, 20 << 16, 20 << 16, 10 << 16, 10 << 16);
        send_ray(0, 0, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF);
        send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_ray(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // random: mostly aimed rays, some raw words; one long answer hold-off
        for (int i = 0; i < NumRandom; i++)
        begin
            if (i == 300) stall_on = 1'b1;
            if ($urandom_range(0, 4) == 0)
                send_ray(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                         rnd_word(), rnd_word(), rnd_word(), rnd_word());
            else
                send_aimed();
            if ($urandom_range(0, 40) == 0)
            begin
                // idle pause: drop valid so the last transfer is not repeated
                query.valid <= 1'b0;
                repeat ($urandom_range(0, 60)) @(negedge clk);
            end
        end
        query.valid <= 1'b0;

        // drain
        wait_cnt = 0;
        while (board.pending.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (PipeDepth * 2) @(posedge clk);

        $display("%0d rays sent, %0d checked (%0d on the axis paths, %0d slab), %0d hits",
                 sent, board.checked, board.axis_rays, board.slab_rays, board.hits);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d answers missing", board.errors,
                     board.pending.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
